// File: rtl/core/plcl_pkg.sv
// ----------------------------------------------------------------------------
// plcl_pkg
// Types, codes and helpers shared by the palette class color lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package plcl_pkg;

   localparam int ENTRY_INDEX_BITS = 8;
   localparam int VALUE_BITS       = 32;
   localparam int COLOR_BITS       = 32;
   localparam int CHAN_BITS        = 8;
   localparam int CHANNELS         = 4;

   // 255^3: full scale of layer opacity * value opacity * alpha
   localparam logic [23:0] OPACITY_DIV = 24'(255 * 255 * 255);

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_PIXEL = 1'b1
   } plcl_op_type;

   typedef enum logic [1:0] {
      CSR_NODATA_COLOR    = 2'd0,
      CSR_TRANSPARENCY_ON = 2'd1,
      CSR_ALPHA_BAND_ON   = 2'd2,
      CSR_LAYER_OPACITY   = 2'd3
   } plcl_csr_type;

   // One beat moving down the cell chain. For a load, key/color/flag carry
   // the entry key, premultiplied color and enable; for a pixel they carry
   // the sample, the color of the latest match and the nodata mark.
   typedef struct packed {
      plcl_op_type                 op;
      logic [ENTRY_INDEX_BITS-1:0] index;
      logic [VALUE_BITS-1:0]       key;
      logic [COLOR_BITS-1:0]       color;
      logic                        flag;
      logic                        hit;
      logic [CHAN_BITS-1:0]        alpha;
      logic [CHAN_BITS-1:0]        opacity;
      logic                        eob;
   } plcl_beat_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] nodata_color;
      logic                  transparency_on;
      logic                  alpha_band_on;
      logic [CHAN_BITS-1:0]  layer_opacity;
   } plcl_cfg_type;

   function automatic logic [CHAN_BITS-1:0] premul_channel(
      input logic [CHAN_BITS-1:0] c,
      input logic [CHAN_BITS-1:0] a
   );
      logic [15:0] t;
      logic [16:0] s;
      begin
         t = 16'(c) * 16'(a);
         s = 17'(t) + 17'(t[15:8]) + 17'd128;
         return s[15:8];
      end
   endfunction

   function automatic logic [COLOR_BITS-1:0] premultiply(
      input logic [COLOR_BITS-1:0] argb
   );
      logic [CHAN_BITS-1:0] a;
      begin
         a = argb[31:24];
         return {a, premul_channel(argb[23:16], a), premul_channel(argb[15:8], a),
                 premul_channel(argb[7:0], a)};
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/plcl_chan_if.sv
// ----------------------------------------------------------------------------
// plcl_chan_if
// Request and response channels of the palette class color lookup.
// ----------------------------------------------------------------------------
`default_nettype none

interface plcl_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [7:0]         entry_index;
   logic signed [31:0] entry_key;
   logic [31:0]        entry_color;
   logic               entry_enable;
   logic signed [31:0] pixel_value;
   logic               pixel_nodata;
   logic [7:0]         alpha_sample;
   logic [7:0]         value_opacity;
   logic               end_of_block;

   modport source (
      output valid, opcode, entry_index, entry_key, entry_color, entry_enable,
             pixel_value, pixel_nodata, alpha_sample, value_opacity, end_of_block,
      input  ready
   );
   modport sink (
      input  valid, opcode, entry_index, entry_key, entry_color, entry_enable,
             pixel_value, pixel_nodata, alpha_sample, value_opacity, end_of_block,
      output ready
   );
endinterface

interface plcl_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_color;
   logic        class_hit;
   logic        end_of_block_out;

   modport source (
      output valid, pixel_color, class_hit, end_of_block_out,
      input  ready
   );
   modport sink (
      input  valid, pixel_color, class_hit, end_of_block_out,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/core/plcl_cell.sv
// ----------------------------------------------------------------------------
// plcl_cell
// One table slot of the lookup chain: takes loads addressed to it and
// marks passing pixels whose value matches its enabled key.
// ----------------------------------------------------------------------------
`default_nettype none

module plcl_cell #(
   parameter int CELL_INDEX = 0,
   parameter int CMP_BITS   = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    valid_i,
   input  plcl_pkg::plcl_beat_type beat_i,
   output logic                    valid_o,
   output plcl_pkg::plcl_beat_type beat_o
);
   import plcl_pkg::*;

   localparam bit IN_RANGE = CELL_INDEX < (1 << ENTRY_INDEX_BITS);
   localparam logic [ENTRY_INDEX_BITS-1:0] CELL_CODE = ENTRY_INDEX_BITS'(CELL_INDEX);

   logic [CMP_BITS-1:0]   key_ff;
   logic [COLOR_BITS-1:0] color_ff;
   logic                  slot_valid_ff;
   logic                  valid_ff;
   plcl_beat_type         beat_ff;
   plcl_beat_type         beat_in;
   logic                  load_sel;
   logic                  key_match;

   always_comb begin
      load_sel  = valid_i && (beat_i.op == OP_LOAD) && IN_RANGE &&
                  (beat_i.index == CELL_CODE);
      key_match = valid_i && (beat_i.op == OP_PIXEL) && !beat_i.flag &&
                  slot_valid_ff && (key_ff == beat_i.key[CMP_BITS-1:0]);
      beat_in = beat_i;
      // later slot overrides any earlier match
      if (key_match) begin
         beat_in.hit   = 1'b1;
         beat_in.color = color_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         slot_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
         if (load_sel) begin
            slot_valid_ff <= beat_i.flag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         beat_ff <= beat_in;
         if (load_sel) begin
            key_ff   <= beat_i.key[CMP_BITS-1:0];
            color_ff <= beat_i.color;
         end
      end
   end

   assign valid_o = valid_ff;
   assign beat_o  = beat_ff;

endmodule

`default_nettype wire

// File: rtl/core/plcl_scale.sv
// ----------------------------------------------------------------------------
// plcl_scale
// Opacity pipeline after the chain: picks the nodata or table color, or
// scales the table color by layer, value and alpha opacity over 255^3.
// ----------------------------------------------------------------------------
`default_nettype none

module plcl_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    valid_i,
   input  plcl_pkg::plcl_beat_type beat_i,
   input  plcl_pkg::plcl_cfg_type  cfg,
   output logic                    valid_o,
   output logic [31:0]             color_o,
   output logic                    hit_o,
   output logic                    eob_o
);
   import plcl_pkg::*;

   // floor(x / 255^3) == (x * RECIP) >> 56 for every 32-bit x
   localparam int RSHIFT = 56;
   localparam logic [32:0] RECIP =
      33'(((65'd1 << RSHIFT) + 65'(OPACITY_DIV) - 65'd1) / 65'(OPACITY_DIV));

   // stage 1: select and first product
   logic                  s1_valid_ff;
   logic                  s1_scale_ff, s1_scale_in;
   logic [COLOR_BITS-1:0] s1_base_ff, s1_base_in;
   logic [COLOR_BITS-1:0] s1_color_ff;
   logic [15:0]           s1_ov_ff;
   logic [CHAN_BITS-1:0]  s1_alpha_ff;
   logic                  s1_hit_ff;
   logic                  s1_eob_ff;

   // stage 2: full opacity factor
   logic                  s2_valid_ff;
   logic                  s2_scale_ff;
   logic [COLOR_BITS-1:0] s2_base_ff;
   logic [COLOR_BITS-1:0] s2_color_ff;
   logic [23:0]           s2_f_ff;
   logic                  s2_hit_ff;
   logic                  s2_eob_ff;

   // stage 3: per-channel products
   logic                  s3_valid_ff;
   logic                  s3_scale_ff;
   logic [COLOR_BITS-1:0] s3_base_ff;
   logic [31:0]           s3_x_ff [CHANNELS];
   logic                  s3_hit_ff;
   logic                  s3_eob_ff;

   // output register
   logic                  out_valid_ff;
   logic [COLOR_BITS-1:0] out_color_ff, out_color_in;
   logic                  out_hit_ff;
   logic                  out_eob_ff;
   logic [64:0]           quot_prod [CHANNELS];
   logic [COLOR_BITS-1:0] scaled;

   always_comb begin
      s1_scale_in = beat_i.hit && cfg.transparency_on &&
                    !(cfg.alpha_band_on && (beat_i.alpha == '0));
      if (beat_i.hit && !cfg.transparency_on) begin
         s1_base_in = beat_i.color;
      end else begin
         s1_base_in = cfg.nodata_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         // drop load beats here
         s1_valid_ff  <= valid_i && (beat_i.op == OP_PIXEL);
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_scale_ff <= s1_scale_in;
         s1_base_ff  <= s1_base_in;
         s1_color_ff <= beat_i.color;
         s1_ov_ff    <= 16'(cfg.layer_opacity) * 16'(beat_i.opacity);
         s1_alpha_ff <= cfg.alpha_band_on ? beat_i.alpha : {CHAN_BITS{1'b1}};
         s1_hit_ff   <= beat_i.hit;
         s1_eob_ff   <= beat_i.eob;

         s2_scale_ff <= s1_scale_ff;
         s2_base_ff  <= s1_base_ff;
         s2_color_ff <= s1_color_ff;
         s2_f_ff     <= 24'(s1_ov_ff) * 24'(s1_alpha_ff);
         s2_hit_ff   <= s1_hit_ff;
         s2_eob_ff   <= s1_eob_ff;

         s3_scale_ff <= s2_scale_ff;
         s3_base_ff  <= s2_base_ff;
         s3_hit_ff   <= s2_hit_ff;
         s3_eob_ff   <= s2_eob_ff;

         out_color_ff <= out_color_in;
         out_hit_ff   <= s3_hit_ff;
         out_eob_ff   <= s3_eob_ff;
      end
   end

   for (genvar k = 0; k < CHANNELS; k++) begin : g_chan
      always_ff @(posedge clock) begin
         if (advance) begin
            s3_x_ff[k] <= 32'(s2_f_ff) *
                          32'(s2_color_ff[k*CHAN_BITS +: CHAN_BITS]);
         end
      end

      assign quot_prod[k] = 65'(s3_x_ff[k]) * 65'(RECIP);
      assign scaled[k*CHAN_BITS +: CHAN_BITS] = quot_prod[k][RSHIFT +: CHAN_BITS];
   end

   assign out_color_in = s3_scale_ff ? scaled : s3_base_ff;

   assign valid_o = out_valid_ff;
   assign color_o = out_color_ff;
   assign hit_o   = out_hit_ff;
   assign eob_o   = out_eob_ff;

endmodule

`default_nettype wire

// File: rtl/core/palette_class_color_lookup.sv
// Each beat passes one cell register per slot, then s1, s2, s3 and output.
// One item per cycle while not held; loads and pixels share one cell chain.
// The whole chain advances together and holds while a response waits.
// Reset clears slot valid bits, pipeline and config; layer opacity is 255.
// Slot keys and colors are written only by load beats.
// ----------------------------------------------------------------------------
// palette_class_color_lookup
// Class value to premultiplied ARGB lookup built as a chain of slot cells
// followed by an opacity scaling pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_class_color_lookup #(
   parameter int TABLE_ENTRIES = 256,
   parameter int KEY_BITS      = 32
) (
   input  logic        clock,
   input  logic        reset,
   plcl_req_if.sink    req_chan,
   plcl_rsp_if.source  rsp_chan,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import plcl_pkg::*;

   localparam int CMP_BITS = (KEY_BITS < VALUE_BITS) ? KEY_BITS : VALUE_BITS;

   logic                  nodata_color_ff;
   logic [COLOR_BITS-1:0] nodata_ff;
   logic                  transparency_on_ff;
   logic                  alpha_band_on_ff;
   logic [CHAN_BITS-1:0]  layer_opacity_ff;
   plcl_cfg_type          cfg;

   logic                  advance;
   logic                  rsp_valid;
   logic                  chain_valid [TABLE_ENTRIES+1];
   plcl_beat_type         chain_beat  [TABLE_ENTRIES+1];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nodata_color_ff    <= 1'b0;
         nodata_ff          <= '0;
         transparency_on_ff <= 1'b0;
         alpha_band_on_ff   <= 1'b0;
         layer_opacity_ff   <= {CHAN_BITS{1'b1}};
      end else if (csr_write_en) begin
         case (plcl_csr_type'(csr_index))
            CSR_NODATA_COLOR: begin
               nodata_ff       <= csr_write_data;
               nodata_color_ff <= 1'b1;
            end
            CSR_TRANSPARENCY_ON: transparency_on_ff <= csr_write_data[0];
            CSR_ALPHA_BAND_ON:   alpha_band_on_ff   <= csr_write_data[0];
            CSR_LAYER_OPACITY:   layer_opacity_ff   <= csr_write_data[CHAN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.nodata_color    = nodata_color_ff ? nodata_ff : '0;
      cfg.transparency_on = transparency_on_ff;
      cfg.alpha_band_on   = alpha_band_on_ff;
      cfg.layer_opacity   = layer_opacity_ff;
   end

   // the chain moves whenever the response register is free or drains
   assign advance        = !rsp_valid || rsp_chan.ready;
   assign req_chan.ready = advance && !reset;

   always_comb begin
      chain_valid[0]       = req_chan.valid;
      chain_beat[0].op     = plcl_op_type'(req_chan.opcode);
      chain_beat[0].index  = req_chan.entry_index;
      chain_beat[0].key    = (plcl_op_type'(req_chan.opcode) == OP_LOAD) ?
                             req_chan.entry_key : req_chan.pixel_value;
      chain_beat[0].color  = premultiply(req_chan.entry_color);
      chain_beat[0].flag   = (plcl_op_type'(req_chan.opcode) == OP_LOAD) ?
                             req_chan.entry_enable : req_chan.pixel_nodata;
      chain_beat[0].hit    = 1'b0;
      chain_beat[0].alpha  = req_chan.alpha_sample;
      chain_beat[0].opacity = req_chan.value_opacity;
      chain_beat[0].eob    = req_chan.end_of_block;
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      plcl_cell #(
         .CELL_INDEX (i),
         .CMP_BITS   (CMP_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .valid_i (chain_valid[i]),
         .beat_i  (chain_beat[i]),
         .valid_o (chain_valid[i+1]),
         .beat_o  (chain_beat[i+1])
      );
   end

   plcl_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .valid_i (chain_valid[TABLE_ENTRIES]),
      .beat_i  (chain_beat[TABLE_ENTRIES]),
      .cfg     (cfg),
      .valid_o (rsp_valid),
      .color_o (rsp_chan.pixel_color),
      .hit_o   (rsp_chan.class_hit),
      .eob_o   (rsp_chan.end_of_block_out)
   );

   assign rsp_chan.valid = rsp_valid;

endmodule

`default_nettype wire

// File: tb/sv/palette_class_color_lookup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_class_color_lookup_tb
// Self-checking bench for the palette class color lookup. Table loads and
// pixel beats go in on the request channel. A local palette and config copy
// predicts every response, and each response beat is compared field by
// field. Traffic runs under random idling on both sides and one long output
// stall.
// ----------------------------------------------------------------------------
module palette_class_color_lookup_tb;
   import plcl_pkg::*;

   localparam int SLOTS         = 256;
   localparam int PIPE_LATENCY  = SLOTS + 4;
   localparam int SETTLE_CYCLES = PIPE_LATENCY + 16;
   localparam int HOLD_CYCLES   = 1000;
   localparam int CYCLE_LIMIT   = 200000;
   localparam longint unsigned FULL_SCALE = 64'd16581375;

   typedef struct packed {
      plcl_op_type        op;
      logic [7:0]         index;
      logic signed [31:0] key;
      logic [31:0]        color;
      logic               enable;
      logic signed [31:0] value;
      logic               nodata;
      logic [7:0]         alpha;
      logic [7:0]         opacity;
      logic               eob;
   } lookup_item_type;

   typedef struct packed {
      logic [31:0] color;
      logic        hit;
      logic        eob;
   } pixel_result_type;

   logic          clock;
   logic          reset;
   logic          csr_write_en;
   plcl_csr_type  csr_index;
   logic [31:0]   csr_write_data;

   plcl_req_if req_chan();
   plcl_rsp_if rsp_chan();

   palette_class_color_lookup dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // local copy of the palette and config registers
   logic [31:0] palette_key   [SLOTS];
   logic [31:0] palette_color [SLOTS];
   bit          palette_live  [SLOTS];
   logic [31:0] cfg_nodata_color  = 32'h0;
   logic        cfg_transparency  = 1'b0;
   logic        cfg_alpha_band    = 1'b0;
   logic [7:0]  cfg_layer_opacity = 8'd255;

   pixel_result_type expected_pixels[$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_req_count;
   int hold_ack_count;
   int hold_left;
   int cycle_count;
   int mismatch_count;
   int load_count;
   int pixel_count;
   int hit_count;
   int checked_count;
   int setting_count;
   int input_stall_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] premultiply_argb(input logic [31:0] argb);
      logic [31:0] res;
      logic [15:0] prod;
      logic [16:0] rounded;
      begin
         res[31:24] = argb[31:24];
         for (int k = 0; k < 3; k++) begin
            prod           = 16'(argb[k*8 +: 8]) * 16'(argb[31:24]);
            rounded        = 17'(prod) + 17'(prod[15:8]) + 17'd128;
            res[k*8 +: 8]  = rounded[15:8];
         end
         return res;
      end
   endfunction

   function automatic logic [7:0] scale_channel(input longint unsigned factor,
                                                input logic [7:0] chan);
      longint unsigned scaled;
      begin
         scaled = factor * 64'(chan) / FULL_SCALE;
         return scaled[7:0];
      end
   endfunction

   function automatic pixel_result_type predict_pixel(input lookup_item_type item);
      pixel_result_type res;
      int               winner;
      longint unsigned  factor;
      logic [31:0]      stored;
      begin
         res.color = cfg_nodata_color;
         res.hit   = 1'b0;
         res.eob   = item.eob;
         winner    = -1;
         // later slots override earlier ones: highest index wins a tie
         if (!item.nodata)
            for (int i = 0; i < SLOTS; i++)
               if (palette_live[i] && palette_key[i] == item.value) winner = i;
         if (winner >= 0) begin
            stored  = palette_color[winner];
            res.hit = 1'b1;
            if (!cfg_transparency) begin
               res.color = stored;
            end else if (cfg_alpha_band && item.alpha == 8'd0) begin
               res.color = cfg_nodata_color;
            end else begin
               factor = 64'(cfg_layer_opacity);
               factor = factor * 64'(item.opacity) *
                        64'(cfg_alpha_band ? item.alpha : 8'd255);
               for (int k = 0; k < 4; k++)
                  res.color[k*8 +: 8] = scale_channel(factor, stored[k*8 +: 8]);
            end
         end
         return res;
      end
   endfunction

   // small key set so that pixels hit and slots tie often
   function automatic logic [31:0] pool_key(input int unsigned k);
      case (k)
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return k * 32'h9E37_79B9;
      endcase
   endfunction

   function automatic logic [7:0] skewed_byte();
      int unsigned pick;
      begin
         pick = $urandom_range(9);
         if (pick == 0) return 8'd0;
         if (pick == 1) return 8'd255;
         return 8'($urandom);
      end
   endfunction

   function automatic lookup_item_type random_item();
      lookup_item_type it;
      int unsigned     pick;
      begin
         it.op     = ($urandom_range(3) == 0) ? OP_LOAD : OP_PIXEL;
         it.index  = 8'($urandom);
         it.key    = ($urandom_range(9) < 6) ? pool_key($urandom_range(15)) : $urandom;
         it.color  = $urandom;
         pick      = $urandom_range(9);
         if (pick == 0) it.color[31:24] = 8'h00;
         else if (pick == 1) it.color[31:24] = 8'hFF;
         it.enable = ($urandom_range(7) != 0);
         pick      = $urandom_range(19);
         if (pick < 13) it.value = pool_key($urandom_range(15));
         else if (pick < 17) it.value = $urandom;
         else it.value = pool_key($urandom_range(3));
         it.nodata  = ($urandom_range(9) == 0);
         it.alpha   = skewed_byte();
         it.opacity = skewed_byte();
         it.eob     = ($urandom_range(15) == 0);
         return it;
      end
   endfunction

   function automatic lookup_item_type load_item(input logic [7:0] index,
                                                 input logic [31:0] key,
                                                 input logic [31:0] color,
                                                 input logic enable);
      lookup_item_type it;
      begin
         it        = random_item();
         it.op     = OP_LOAD;
         it.index  = index;
         it.key    = key;
         it.color  = color;
         it.enable = enable;
         return it;
      end
   endfunction

   function automatic lookup_item_type pixel_item(input logic [31:0] value,
                                                  input logic nodata,
                                                  input logic [7:0] alpha,
                                                  input logic [7:0] opacity,
                                                  input logic eob);
      lookup_item_type it;
      begin
         it         = random_item();
         it.op      = OP_PIXEL;
         it.value   = value;
         it.nodata  = nodata;
         it.alpha   = alpha;
         it.opacity = opacity;
         it.eob     = eob;
         return it;
      end
   endfunction

   task automatic send_beat(input lookup_item_type item);
      pixel_result_type outcome;
      begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
         req_chan.valid         <= 1'b1;
         req_chan.opcode        <= item.op;
         req_chan.entry_index   <= item.index;
         req_chan.entry_key     <= item.key;
         req_chan.entry_color   <= item.color;
         req_chan.entry_enable  <= item.enable;
         req_chan.pixel_value   <= item.value;
         req_chan.pixel_nodata  <= item.nodata;
         req_chan.alpha_sample  <= item.alpha;
         req_chan.value_opacity <= item.opacity;
         req_chan.end_of_block  <= item.eob;
         @(posedge clock);
         while (!req_chan.ready) @(posedge clock);
         if (item.op == OP_LOAD) begin
            palette_key[item.index]   = item.key;
            palette_color[item.index] = premultiply_argb(item.color);
            palette_live[item.index]  = item.enable;
            load_count++;
         end else begin
            outcome = predict_pixel(item);
            expected_pixels = {expected_pixels, outcome};
            pixel_count++;
            if (outcome.hit) hit_count++;
         end
      end
   endtask

   // loads leave no response, so give the chain its full latency to empty
   task automatic drain_pipeline();
      begin
         req_chan.valid <= 1'b0;
         while (expected_pixels.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end
   endtask

   task automatic write_csr(input plcl_csr_type idx, input logic [31:0] data);
      begin
         csr_write_en   <= 1'b1;
         csr_index      <= idx;
         csr_write_data <= data;
         @(posedge clock);
         csr_write_en <= 1'b0;
         @(posedge clock);
         case (idx)
            CSR_NODATA_COLOR:    cfg_nodata_color  = data;
            CSR_TRANSPARENCY_ON: cfg_transparency  = data[0];
            CSR_ALPHA_BAND_ON:   cfg_alpha_band    = data[0];
            CSR_LAYER_OPACITY:   cfg_layer_opacity = data[7:0];
            default: ;
         endcase
      end
   endtask

   task automatic apply_config(input logic [31:0] nodata_color, input logic transparency,
                               input logic alpha_band, input logic [7:0] layer_opacity);
      begin
         drain_pipeline();
         write_csr(CSR_NODATA_COLOR, nodata_color);
         write_csr(CSR_TRANSPARENCY_ON, {31'd0, transparency});
         write_csr(CSR_ALPHA_BAND_ON, {31'd0, alpha_band});
         write_csr(CSR_LAYER_OPACITY, {24'd0, layer_opacity});
         setting_count++;
      end
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      begin
         send_idle_pct = send_pct;
         recv_idle_pct <= recv_pct;
      end
   endtask

   // match rules under reset config: empty table, key extremes, ties, disable
   task automatic test_lookup_rules();
      begin
         send_beat(pixel_item(32'h0000_0000, 1'b0, 8'd255, 8'd255, 1'b1));
         send_beat(load_item(8'd0, 32'h8000_0000, 32'hFF80_4020, 1'b1));
         send_beat(load_item(8'd255, 32'h7FFF_FFFF, 32'h80FF_FFFF, 1'b1));
         send_beat(load_item(8'd10, 32'd5, 32'h00FF_FFFF, 1'b1));
         send_beat(load_item(8'd11, 32'd5, 32'h7F12_3456, 1'b1));
         send_beat(load_item(8'd12, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
         send_beat(pixel_item(32'h8000_0000, 1'b0, 8'd255, 8'd255, 1'b0));
         send_beat(pixel_item(32'h7FFF_FFFF, 1'b0, 8'd0, 8'd0, 1'b1));
         send_beat(pixel_item(32'd5, 1'b0, 8'd255, 8'd255, 1'b0));
         send_beat(pixel_item(32'hFFFF_FFFF, 1'b1, 8'd255, 8'd255, 1'b0));
         send_beat(pixel_item(32'd12345, 1'b0, 8'd255, 8'd255, 1'b0));
         // clear slot 11; the lower slot with the same key takes over
         send_beat(load_item(8'd11, 32'd5, 32'h7F12_3456, 1'b0));
         send_beat(pixel_item(32'd5, 1'b0, 8'd255, 8'd255, 1'b1));
         send_beat(pixel_item(32'hFFFF_FFFF, 1'b0, 8'd0, 8'd0, 1'b1));
      end
   endtask

   task automatic test_opacity_scaling();
      begin
         apply_config(32'hFFFF_FFFF, 1'b1, 1'b1, 8'd255);
         send_beat(pixel_item(32'hFFFF_FFFF, 1'b0, 8'd0, 8'd255, 1'b0));
         send_beat(pixel_item(32'hFFFF_FFFF, 1'b0, 8'd255, 8'd255, 1'b0));
         send_beat(pixel_item(32'h8000_0000, 1'b0, 8'd128, 8'd200, 1'b0));
         send_beat(pixel_item(32'h7FFF_FFFF, 1'b0, 8'd1, 8'd0, 1'b1));
         // alpha band alone does nothing without transparency
         apply_config(32'h1234_5678, 1'b0, 1'b1, 8'd0);
         send_beat(pixel_item(32'hFFFF_FFFF, 1'b0, 8'd0, 8'd0, 1'b0));
         send_beat(pixel_item(32'd5, 1'b1, 8'd0, 8'd0, 1'b1));
         apply_config(32'h0000_0000, 1'b1, 1'b0, 8'd0);
         send_beat(pixel_item(32'd5, 1'b0, 8'd255, 8'd255, 1'b0));
         apply_config(32'h0000_0000, 1'b1, 1'b0, 8'd255);
         send_beat(pixel_item(32'hFFFF_FFFF, 1'b0, 8'd0, 8'd77, 1'b1));
      end
   endtask

   task automatic test_random_traffic(input int count);
      begin
         repeat (count) send_beat(random_item());
      end
   endtask

   task automatic test_output_stall(input int count);
      begin
         set_idling(0, 0);
         hold_req_count <= hold_req_count + 1;
         repeat (count) send_beat(random_item());
      end
   endtask

   // response side: check each beat, then decide ready for the next cycle
   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_pixels.size() == 0) begin
               $error("response beat with no pixel pending: pixel_color %08h",
                      rsp_chan.pixel_color);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               checked_count++;
               if (rsp_chan.pixel_color !== want.color) begin
                  $error("pixel_color: expected %08h, got %08h", want.color,
                         rsp_chan.pixel_color);
                  mismatch_count++;
               end
               if (rsp_chan.class_hit !== want.hit) begin
                  $error("class_hit: expected %0b, got %0b", want.hit, rsp_chan.class_hit);
                  mismatch_count++;
               end
               if (rsp_chan.end_of_block_out !== want.eob) begin
                  $error("end_of_block_out: expected %0b, got %0b", want.eob,
                         rsp_chan.end_of_block_out);
                  mismatch_count++;
               end
            end
         end
         if (hold_ack_count != hold_req_count) begin
            hold_ack_count <= hold_req_count;
            hold_left      <= HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left      <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (req_chan.valid && !req_chan.ready) input_stall_cycles <= input_stall_cycles + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset                  <= 1'b1;
      csr_write_en           <= 1'b0;
      csr_index              <= CSR_NODATA_COLOR;
      csr_write_data         <= 32'h0;
      req_chan.valid         <= 1'b0;
      req_chan.opcode        <= OP_LOAD;
      req_chan.entry_index   <= 8'h0;
      req_chan.entry_key     <= 32'h0;
      req_chan.entry_color   <= 32'h0;
      req_chan.entry_enable  <= 1'b0;
      req_chan.pixel_value   <= 32'h0;
      req_chan.pixel_nodata  <= 1'b0;
      req_chan.alpha_sample  <= 8'h0;
      req_chan.value_opacity <= 8'h0;
      req_chan.end_of_block  <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      set_idling(17, 86);
      test_lookup_rules();
      test_opacity_scaling();
      apply_config($urandom, 1'b1, 1'b1, 8'($urandom));
      test_random_traffic(180);
      apply_config(32'h0000_0000, 1'b1, 1'b0, 8'd255);
      test_random_traffic(180);

      set_idling(86, 17);
      apply_config(32'hFFFF_FFFF, 1'b0, 1'b1, 8'd0);
      test_random_traffic(180);
      apply_config($urandom, 1'b1, 1'b1, 8'd0);
      test_random_traffic(180);

      set_idling(0, 0);
      apply_config($urandom, 1'b1, 1'b1, 8'd255);
      test_random_traffic(180);
      test_output_stall(400);

      drain_pipeline();
      $display("Covered %0d loads and %0d pixels (%0d class hits); %0d responses checked.",
               load_count, pixel_count, hit_count, checked_count);
      $display("Config settings applied: %0d; request channel stalled for %0d cycles.",
               setting_count, input_stall_cycles);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/plcl_pkg.sv
rtl/core/plcl_chan_if.sv
rtl/core/plcl_cell.sv
rtl/core/plcl_scale.sv
rtl/core/palette_class_color_lookup.sv
tb/sv/palette_class_color_lookup_tb.sv
